// ----- rtl/salf_pkg.sv -----
// shared types and constants of the set-associative cache model
`default_nettype none
package salf_pkg;

    localparam int COUNT_BITS = 32;
    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 32;
    localparam int CFG_BITS   = 4;

    localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] REG_SET_BITS    = 2'd1;
    localparam logic [1:0] REG_WAYS        = 2'd2;
    localparam logic [1:0] REG_POLICY      = 2'd3;

    localparam logic [CFG_BITS-1:0] RST_OFFSET_BITS = 4'd4;
    localparam logic [CFG_BITS-1:0] RST_SET_BITS    = 4'd5;
    localparam logic [CFG_BITS-1:0] RST_WAYS        = 4'd1;
    localparam logic                RST_POLICY      = 1'b0;

    localparam logic POLICY_LRU = 1'b1;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic [CFG_BITS-1:0] offset_bits;
        logic [CFG_BITS-1:0] set_bits;
        logic [CFG_BITS-1:0] ways;
        logic                replace_policy;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic shift;
        logic split;
        logic step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic last;
    } status_t;

endpackage
`default_nettype wire

// ----- rtl/salf_regs.sv -----
// apb configuration registers of the cache model
`default_nettype none
module salf_regs
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [salf_pkg::PADDR_BITS-1:0]   paddr,
    input  wire logic [salf_pkg::PDATA_BITS-1:0]   pwdata,
    output logic      [salf_pkg::PDATA_BITS-1:0]   prdata,
    output logic                                   pready,
    output salf_pkg::cfg_t                         cfg
);

    salf_pkg::cfg_t cfg_reg;
    salf_pkg::cfg_t cfg_next;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                salf_pkg::REG_OFFSET_BITS: cfg_next.offset_bits    = pwdata[3:0];
                salf_pkg::REG_SET_BITS:    cfg_next.set_bits       = pwdata[3:0];
                salf_pkg::REG_WAYS:        cfg_next.ways           = pwdata[3:0];
                salf_pkg::REG_POLICY:      cfg_next.replace_policy = pwdata[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_bits    <= salf_pkg::RST_OFFSET_BITS;
            cfg_reg.set_bits       <= salf_pkg::RST_SET_BITS;
            cfg_reg.ways           <= salf_pkg::RST_WAYS;
            cfg_reg.replace_policy <= salf_pkg::RST_POLICY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            salf_pkg::REG_OFFSET_BITS: prdata = {28'd0, cfg_reg.offset_bits};
            salf_pkg::REG_SET_BITS:    prdata = {28'd0, cfg_reg.set_bits};
            salf_pkg::REG_WAYS:        prdata = {28'd0, cfg_reg.ways};
            salf_pkg::REG_POLICY:      prdata = {31'd0, cfg_reg.replace_policy};
            default:                   prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/salf_datapath.sv -----
// address split, tag and stamp memories, way scan and running totals
`default_nettype none
module salf_datapath
#(
    parameter int MAX_SETS     = 256,
    parameter int MAX_WAYS     = 8,
    parameter int ADDRESS_BITS = 48,
    parameter int STAMP_BITS   = 32
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  salf_pkg::cfg_t                         cfg,
    input  salf_pkg::cmd_t                         cmd,
    output salf_pkg::status_t                      status,
    input  wire logic                              kind,
    input  wire logic [ADDRESS_BITS-1:0]           address,
    output logic                                   hit,
    output logic                                   mem_read,
    output logic                                   mem_write,
    output logic      [salf_pkg::COUNT_BITS-1:0]   hit_count,
    output logic      [salf_pkg::COUNT_BITS-1:0]   miss_count,
    output logic      [salf_pkg::COUNT_BITS-1:0]   read_count,
    output logic      [salf_pkg::COUNT_BITS-1:0]   write_count
);

    localparam int SB_MAX       = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_IDX_BITS = (SB_MAX > 0) ? SB_MAX : 1;
    localparam int WAY_BITS     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int FILL_BITS    = $clog2(MAX_WAYS + 1);
    localparam int ROWS         = 2 ** SET_IDX_BITS;
    localparam int SLOTS        = ROWS * (2 ** WAY_BITS);
    localparam int CNT          = salf_pkg::COUNT_BITS;

    logic [ADDRESS_BITS-1:0] tag_mem    [SLOTS];
    logic [STAMP_BITS-1:0]   stamp_mem  [SLOTS];
    logic [FILL_BITS-1:0]    fill_mem   [ROWS];
    logic [STAMP_BITS-1:0]   sstamp_mem [ROWS];
    logic [ROWS-1:0]         init_reg;

    logic                    kind_reg;
    logic [ADDRESS_BITS-1:0] addr_reg;
    logic [ADDRESS_BITS-1:0] block_reg;
    logic [SET_IDX_BITS-1:0] set_reg;
    logic [ADDRESS_BITS-1:0] tag_reg;
    logic [WAY_BITS-1:0]     way_reg;
    logic [WAY_BITS-1:0]     cmp_way_reg;
    logic [ADDRESS_BITS-1:0] tag_rd_reg;
    logic [STAMP_BITS-1:0]   stamp_rd_reg;
    logic [FILL_BITS-1:0]    fill_rd_reg;
    logic [STAMP_BITS-1:0]   sstamp_rd_reg;
    logic                    init_rd_reg;
    logic                    hit_reg;
    logic [WAY_BITS-1:0]     hit_way_reg;
    logic [STAMP_BITS-1:0]   best_reg;
    logic [WAY_BITS-1:0]     min_way_reg;

    logic [CNT-1:0] hit_total_reg;
    logic [CNT-1:0] miss_total_reg;
    logic [CNT-1:0] read_total_reg;
    logic [CNT-1:0] write_total_reg;
    logic [CNT-1:0] hit_total_next;
    logic [CNT-1:0] miss_total_next;
    logic [CNT-1:0] read_total_next;
    logic [CNT-1:0] write_total_next;

    logic           out_hit_reg;
    logic           out_mem_read_reg;
    logic           out_mem_write_reg;
    logic [CNT-1:0] out_hit_count_reg;
    logic [CNT-1:0] out_miss_count_reg;
    logic [CNT-1:0] out_read_count_reg;
    logic [CNT-1:0] out_write_count_reg;

    logic [FILL_BITS-1:0]          nw;
    logic [salf_pkg::CFG_BITS-1:0] sb;
    logic [FILL_BITS-1:0]          fill_eff;
    logic [STAMP_BITS-1:0]         stamp_eff;
    logic                          fill_free;
    logic [WAY_BITS-1:0]           victim;
    logic [FILL_BITS-1:0]          fill_new;
    logic                          stamp_wr;
    logic                          is_write;
    logic [SET_IDX_BITS+WAY_BITS-1:0] rd_addr;
    logic [SET_IDX_BITS+WAY_BITS-1:0] wr_addr;

    // effective geometry
    always_comb
    begin
        if (cfg.ways == '0)
        begin
            nw = FILL_BITS'(1);
        end
        else if (int'(cfg.ways) > MAX_WAYS)
        begin
            nw = FILL_BITS'(MAX_WAYS);
        end
        else
        begin
            nw = FILL_BITS'(cfg.ways);
        end
        sb = (int'(cfg.set_bits) > SB_MAX) ? salf_pkg::CFG_BITS'(SB_MAX) : cfg.set_bits;
    end

    // an untouched set reads as empty with a zero counter
    assign fill_eff  = init_rd_reg ? fill_rd_reg : '0;
    assign stamp_eff = init_rd_reg ? sstamp_rd_reg : '0;
    assign fill_free = fill_eff < nw;
    assign victim    = hit_reg ? hit_way_reg
                     : (fill_free ? WAY_BITS'(fill_eff) : min_way_reg);
    assign fill_new  = (!hit_reg && fill_free) ? fill_eff + FILL_BITS'(1) : fill_eff;
    assign stamp_wr  = !hit_reg || (cfg.replace_policy == salf_pkg::POLICY_LRU);
    assign is_write  = (kind_reg == salf_pkg::KIND_WRITE);
    assign rd_addr   = {set_reg, way_reg};
    assign wr_addr   = {set_reg, victim};

    assign status.match = (FILL_BITS'(cmp_way_reg) < fill_eff) && (tag_rd_reg == tag_reg);
    assign status.last  = (FILL_BITS'(cmp_way_reg) == (nw - FILL_BITS'(1)));

    // address split
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg <= kind;
            addr_reg <= address;
        end
        if (cmd.shift)
        begin
            block_reg <= addr_reg >> cfg.offset_bits;
        end
        if (cmd.split)
        begin
            set_reg <= SET_IDX_BITS'(block_reg) & ~({SET_IDX_BITS{1'b1}} << sb);
            tag_reg <= block_reg >> sb;
        end
    end

    // way scan
    always_ff @(posedge clk)
    begin
        cmp_way_reg <= way_reg;
        if (cmd.split)
        begin
            way_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            way_reg <= way_reg + WAY_BITS'(1);
        end
        if (cmd.step)
        begin
            if (status.match)
            begin
                hit_reg     <= 1'b1;
                hit_way_reg <= cmp_way_reg;
            end
            if ((cmp_way_reg == '0) || (stamp_rd_reg < best_reg))
            begin
                best_reg    <= stamp_rd_reg;
                min_way_reg <= cmp_way_reg;
            end
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        tag_rd_reg    <= tag_mem[rd_addr];
        stamp_rd_reg  <= stamp_mem[rd_addr];
        fill_rd_reg   <= fill_mem[set_reg];
        sstamp_rd_reg <= sstamp_mem[set_reg];
        if (cmd.commit && !hit_reg)
        begin
            tag_mem[wr_addr] <= tag_reg;
        end
        if (cmd.commit && stamp_wr)
        begin
            stamp_mem[wr_addr]  <= stamp_eff;
            sstamp_mem[set_reg] <= stamp_eff + STAMP_BITS'(1);
            fill_mem[set_reg]   <= fill_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg    <= '0;
            init_rd_reg <= 1'b0;
        end
        else
        begin
            init_rd_reg <= init_reg[set_reg];
            if (cmd.commit && stamp_wr)
            begin
                init_reg[set_reg] <= 1'b1;
            end
        end
    end

    // running totals
    always_comb
    begin
        hit_total_next   = hit_total_reg;
        miss_total_next  = miss_total_reg;
        read_total_next  = read_total_reg;
        write_total_next = write_total_reg;
        if (hit_reg)
        begin
            hit_total_next = hit_total_reg + CNT'(1);
        end
        else
        begin
            miss_total_next = miss_total_reg + CNT'(1);
            read_total_next = read_total_reg + CNT'(1);
        end
        if (is_write)
        begin
            write_total_next = write_total_reg + CNT'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            read_total_reg  <= '0;
            write_total_reg <= '0;
        end
        else if (cmd.commit)
        begin
            hit_total_reg   <= hit_total_next;
            miss_total_reg  <= miss_total_next;
            read_total_reg  <= read_total_next;
            write_total_reg <= write_total_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hit_reg         <= hit_reg;
            out_mem_read_reg    <= !hit_reg;
            out_mem_write_reg   <= is_write;
            out_hit_count_reg   <= hit_total_next;
            out_miss_count_reg  <= miss_total_next;
            out_read_count_reg  <= read_total_next;
            out_write_count_reg <= write_total_next;
        end
    end

    assign hit         = out_hit_reg;
    assign mem_read    = out_mem_read_reg;
    assign mem_write   = out_mem_write_reg;
    assign hit_count   = out_hit_count_reg;
    assign miss_count  = out_miss_count_reg;
    assign read_count  = out_read_count_reg;
    assign write_count = out_write_count_reg;

endmodule
`default_nettype wire

// ----- rtl/salf_ctrl.sv -----
// sequencing state machine of the cache model
`default_nettype none
module salf_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  salf_pkg::status_t  status,
    output salf_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_SPLIT = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_LOOK  = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                cmd.step = 1'b1;
                if (status.match || status.last)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_SHIFT))
        else $error("accepted transaction did not start the address split");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while still stalled");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("committed result not presented");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK && status.last) |=> (state_reg == S_UPD))
        else $error("way scan ran past the last way");

endmodule
`default_nettype wire

// ----- rtl/set_associative_cache_lru_fifo.sv -----
// top level of the set-associative cache model with fifo or lru replacement
// an accepted transaction runs through shift, split, read, way scan and update before its result is valid
// a new transaction is taken only when idle again; the tag and stamp scan compares one way per cycle
// the scan stops at the first hit; a miss compares all configured ways
// reset: asynchronous, clears state, totals, configuration and per-set empty marks at once
// tag and stamp memories need no clearing pass
`default_nettype none
module set_associative_cache_lru_fifo
#(
    parameter int MAX_SETS     = 256,
    parameter int MAX_WAYS     = 8,
    parameter int ADDRESS_BITS = 48,
    parameter int STAMP_BITS   = 32
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [salf_pkg::PADDR_BITS-1:0]   paddr,
    input  wire logic [salf_pkg::PDATA_BITS-1:0]   pwdata,
    output logic      [salf_pkg::PDATA_BITS-1:0]   prdata,
    output logic                                   pready,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              kind,
    input  wire logic [ADDRESS_BITS-1:0]           address,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   hit,
    output logic                                   mem_read,
    output logic                                   mem_write,
    output logic      [salf_pkg::COUNT_BITS-1:0]   hit_count,
    output logic      [salf_pkg::COUNT_BITS-1:0]   miss_count,
    output logic      [salf_pkg::COUNT_BITS-1:0]   read_count,
    output logic      [salf_pkg::COUNT_BITS-1:0]   write_count
);

    salf_pkg::cfg_t    cfg;
    salf_pkg::cmd_t    cmd;
    salf_pkg::status_t status;

    salf_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    salf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    salf_datapath
    #(
        .MAX_SETS     (MAX_SETS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDRESS_BITS (ADDRESS_BITS),
        .STAMP_BITS   (STAMP_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .kind        (kind),
        .address     (address),
        .hit         (hit),
        .mem_read    (mem_read),
        .mem_write   (mem_write),
        .hit_count   (hit_count),
        .miss_count  (miss_count),
        .read_count  (read_count),
        .write_count (write_count)
    );

endmodule
`default_nettype wire
